// File: rtl/bbsk_pkg.sv
// ----------------------------------------------------------------------------
// bbsk_pkg
// Shared constants, codes and beat types of the banked best score keeper.
// ----------------------------------------------------------------------------
package bbsk_pkg;

  localparam int NUM_BANKS = 4;
  localparam int SLOTS     = 8;
  localparam int KEY_BYTES = 4;

  localparam int MODE_W    = 2;
  localparam int BANK_W    = 2;
  localparam int KEY_W     = 32;
  localparam int SCORE_W   = 16;
  localparam int SLOTOUT_W = 3;
  localparam int CFG_W     = 4;

  localparam int MAX_SHOWN = 8;
  localparam int N_MAX     = (SLOTS < MAX_SHOWN) ? SLOTS : MAX_SHOWN;
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int ENTRIES   = NUM_BANKS * SLOTS;
  localparam int ADDR_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic signed [SCORE_W-1:0] INIT_SCORE = 16'sd25600;
  localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BYTES >= 4) ? {KEY_W{1'b1}} :
    KEY_W'((64'd1 << (8 * KEY_BYTES)) - 64'd1);
  localparam logic [CFG_W-1:0] SHOWN_RESET = 4'd8;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DUMP   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = 1;
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = 2;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_DUMP   = 2'd2
  } op_t;

  typedef struct packed {
    op_t                        op;
    logic [BANK_W-1:0]          bank;
    logic [KEY_W-1:0]           key;
    logic signed [SCORE_W-1:0]  score;
    logic [CNT_W-1:0]           n;
  } cmd_t;

  typedef struct packed {
    logic [SLOTOUT_W-1:0]       slot;
    logic [KEY_W-1:0]           key;
    logic signed [SCORE_W-1:0]  score;
    logic                       replaced;
    logic                       last;
  } res_t;

endpackage

// File: rtl/bbsk_front.sv
// ----------------------------------------------------------------------------
// bbsk_front
// Accepts input beats, drops those with no effect and builds commands.
// ----------------------------------------------------------------------------
module bbsk_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  logic [bbsk_pkg::MODE_W-1:0]         mode,
  input  logic [bbsk_pkg::BANK_W-1:0]         bank,
  input  logic [bbsk_pkg::KEY_W-1:0]          key_word,
  input  logic signed [bbsk_pkg::SCORE_W-1:0] cand_score,
  input  logic                                cfg_we,
  input  logic [bbsk_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                q_full,
  output logic                                cmd_push,
  output bbsk_pkg::cmd_t                      cmd
);

  logic [bbsk_pkg::CFG_W-1:0] shown_count;
  logic                       keep;
  logic [bbsk_pkg::CNT_W-1:0] n;

  always_ff @(posedge clk) begin
    if (rst) begin
      shown_count <= bbsk_pkg::SHOWN_RESET;
    end else if (cfg_we) begin
      shown_count <= cfg_wdata;
    end
  end

  always_comb begin
    if (shown_count == '0) begin
      n = bbsk_pkg::CNT_W'(1);
    end else if (int'(shown_count) > bbsk_pkg::N_MAX) begin
      n = bbsk_pkg::CNT_W'(bbsk_pkg::N_MAX);
    end else begin
      n = bbsk_pkg::CNT_W'(shown_count);
    end
  end

  always_comb begin
    cmd.bank  = bank;
    cmd.key   = key_word & bbsk_pkg::KEY_MASK;
    cmd.score = cand_score;
    cmd.n     = n;
    unique case (mode)
      bbsk_pkg::MODE_INSERT: begin
        cmd.op = bbsk_pkg::OP_INSERT;
        keep   = int'(bank) < bbsk_pkg::NUM_BANKS;
      end
      bbsk_pkg::MODE_CLEAR: begin
        cmd.op = bbsk_pkg::OP_CLEAR;
        keep   = 1'b1;
      end
      bbsk_pkg::MODE_DUMP: begin
        cmd.op = bbsk_pkg::OP_DUMP;
        keep   = int'(bank) < bbsk_pkg::NUM_BANKS;
      end
      default: begin
        cmd.op = bbsk_pkg::OP_INSERT;
        keep   = 1'b0;
      end
    endcase
  end

  assign cmd_push = push && !q_full && keep;

endmodule

// File: rtl/bbsk_cmd_fifo.sv
// ----------------------------------------------------------------------------
// bbsk_cmd_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module bbsk_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  bbsk_pkg::cmd_t wdata,
  output logic           full,
  input  logic           rd,
  output logic           valid,
  output bbsk_pkg::cmd_t rdata
);

  bbsk_pkg::cmd_t                 mem [bbsk_pkg::CMD_DEPTH];
  logic [bbsk_pkg::CMD_PTR_W-1:0] wr_ptr;
  logic [bbsk_pkg::CMD_PTR_W-1:0] rd_ptr;
  logic [bbsk_pkg::CMD_PTR_W:0]   count;
  logic                           do_wr;
  logic                           do_rd;

  assign full  = count == (bbsk_pkg::CMD_PTR_W+1)'(bbsk_pkg::CMD_DEPTH);
  assign valid = count != '0;
  assign rdata = mem[rd_ptr];
  assign do_wr = wr && !full;
  assign do_rd = rd && valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (!do_wr && do_rd) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/bbsk_res_fifo.sv
// ----------------------------------------------------------------------------
// bbsk_res_fifo
// Result queue that decouples the back from the receiver.
// ----------------------------------------------------------------------------
module bbsk_res_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  bbsk_pkg::res_t wdata,
  output logic           full,
  input  logic           rd,
  output logic           empty,
  output bbsk_pkg::res_t rdata
);

  bbsk_pkg::res_t                 mem [bbsk_pkg::RES_DEPTH];
  logic [bbsk_pkg::RES_PTR_W-1:0] wr_ptr;
  logic [bbsk_pkg::RES_PTR_W-1:0] rd_ptr;
  logic [bbsk_pkg::RES_PTR_W:0]   count;
  logic                           do_wr;
  logic                           do_rd;

  assign full  = count == (bbsk_pkg::RES_PTR_W+1)'(bbsk_pkg::RES_DEPTH);
  assign empty = count == '0;
  assign rdata = mem[rd_ptr];
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (!do_wr && do_rd) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/bbsk_back.sv
// ----------------------------------------------------------------------------
// bbsk_back
// Executes commands against the key and score stores: max scan and replace,
// clear, and insertion sort into a row of cells followed by write back/emit.
// ----------------------------------------------------------------------------
module bbsk_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  bbsk_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic           res_full,
  output logic           res_push,
  output bbsk_pkg::res_t res
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_INS   = 5'b00100,
    S_LOAD  = 5'b01000,
    S_DRAIN = 5'b10000
  } state_t;

  state_t                                state;
  bbsk_pkg::cmd_t                        cur;
  logic [bbsk_pkg::CNT_W-1:0]            cnt;
  logic signed [bbsk_pkg::SCORE_W-1:0]   mx;
  logic [bbsk_pkg::SLOT_W-1:0]           at;
  logic                                  found;

  logic [bbsk_pkg::KEY_W-1:0]            key_mem   [bbsk_pkg::ENTRIES];
  logic signed [bbsk_pkg::SCORE_W-1:0]   score_mem [bbsk_pkg::ENTRIES];
  logic [bbsk_pkg::ENTRIES-1:0]          s_vld;
  logic [bbsk_pkg::ENTRIES-1:0]          k_vld;

  logic [bbsk_pkg::KEY_W-1:0]            rd_key;
  logic signed [bbsk_pkg::SCORE_W-1:0]   rd_score;
  logic                                  rd_svld;
  logic                                  rd_kvld;
  logic                                  rd_en;
  logic                                  rd_last;
  logic [bbsk_pkg::SLOT_W-1:0]           rd_slot;
  logic signed [bbsk_pkg::SCORE_W-1:0]   eff_s;
  logic [bbsk_pkg::KEY_W-1:0]            eff_k;

  logic [bbsk_pkg::KEY_W-1:0]            c_key   [bbsk_pkg::SLOTS];
  logic signed [bbsk_pkg::SCORE_W-1:0]   c_score [bbsk_pkg::SLOTS];
  logic [bbsk_pkg::SLOTS-1:0]            c_occ;
  logic [bbsk_pkg::SLOTS-1:0]            gt;

  logic [bbsk_pkg::ADDR_W-1:0]           base;
  logic [bbsk_pkg::ADDR_W-1:0]           ra;
  logic                                  we;
  logic [bbsk_pkg::ADDR_W-1:0]           wa;
  logic [bbsk_pkg::KEY_W-1:0]            wk;
  logic signed [bbsk_pkg::SCORE_W-1:0]   ws;
  logic                                  issuing;
  logic                                  hit;
  logic                                  show;
  logic                                  go;

  assign base    = bbsk_pkg::ADDR_W'(cur.bank) * bbsk_pkg::ADDR_W'(bbsk_pkg::SLOTS);
  assign ra      = base + bbsk_pkg::ADDR_W'(cnt);
  assign issuing = (state == S_SCAN || state == S_LOAD) &&
                   (cnt < bbsk_pkg::CNT_W'(bbsk_pkg::SLOTS));
  assign eff_s   = rd_svld ? rd_score : bbsk_pkg::INIT_SCORE;
  assign eff_k   = rd_kvld ? rd_key : '0;
  assign hit     = found && (mx > cur.score);
  assign show    = cnt < cur.n;
  assign go      = !(show && res_full);
  assign cmd_pop = (state == S_IDLE) && cmd_valid;

  // store read, one entry a cycle
  always_ff @(posedge clk) begin
    rd_key   <= key_mem[ra];
    rd_score <= score_mem[ra];
    rd_svld  <= s_vld[ra];
    rd_kvld  <= k_vld[ra];
    rd_slot  <= bbsk_pkg::SLOT_W'(cnt);
    rd_last  <= cnt == bbsk_pkg::CNT_W'(bbsk_pkg::SLOTS - 1);
  end

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[wa]   <= wk;
      score_mem[wa] <= ws;
    end
  end

  // unwritten entries read as their reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= '0;
      k_vld <= '0;
    end else if (cmd_pop && cmd.op == bbsk_pkg::OP_CLEAR) begin
      s_vld <= '0;
    end else if (we) begin
      s_vld[wa] <= 1'b1;
      k_vld[wa] <= 1'b1;
    end
  end

  always_comb begin
    we       = 1'b0;
    wa       = base + bbsk_pkg::ADDR_W'(cnt);
    wk       = c_key[0];
    ws       = c_score[0];
    res_push = 1'b0;
    res      = '0;
    unique case (state)
      S_INS: begin
        wa       = base + bbsk_pkg::ADDR_W'(at);
        wk       = cur.key;
        ws       = cur.score;
        we       = hit && !res_full;
        res_push = !res_full;
        res.last = 1'b1;
        if (hit) begin
          res.slot     = bbsk_pkg::SLOTOUT_W'(at);
          res.key      = cur.key;
          res.score    = cur.score;
          res.replaced = 1'b1;
        end
      end
      S_DRAIN: begin
        we        = go;
        res_push  = go && show;
        res.slot  = bbsk_pkg::SLOTOUT_W'(cnt);
        res.key   = c_key[0];
        res.score = c_score[0];
        res.last  = cnt == (cur.n - bbsk_pkg::CNT_W'(1));
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < bbsk_pkg::SLOTS; i++) begin
      gt[i] = !c_occ[i] || (c_score[i] > eff_s);
    end
  end

  // sorted row: an arriving entry goes after every equal score already held
  always_ff @(posedge clk) begin
    if (state == S_LOAD && rd_en) begin
      if (gt[0]) begin
        c_key[0]   <= eff_k;
        c_score[0] <= eff_s;
      end
      for (int i = 1; i < bbsk_pkg::SLOTS; i++) begin
        if (gt[i]) begin
          if (gt[i-1]) begin
            c_key[i]   <= c_key[i-1];
            c_score[i] <= c_score[i-1];
          end else begin
            c_key[i]   <= eff_k;
            c_score[i] <= eff_s;
          end
        end
      end
    end else if (state == S_DRAIN && go) begin
      for (int i = 0; i < bbsk_pkg::SLOTS - 1; i++) begin
        c_key[i]   <= c_key[i+1];
        c_score[i] <= c_score[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_occ <= '0;
    end else if (cmd_pop) begin
      c_occ <= '0;
    end else if (state == S_LOAD && rd_en) begin
      c_occ[0] <= 1'b1;
      for (int i = 1; i < bbsk_pkg::SLOTS; i++) begin
        if (gt[i]) begin
          c_occ[i] <= gt[i-1] ? c_occ[i-1] : 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
    if (state == S_SCAN && rd_en && (eff_s > mx)) begin
      mx <= eff_s;
      at <= rd_slot;
    end else if (cmd_pop) begin
      mx <= '0;
      at <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      rd_en <= 1'b0;
      found <= 1'b0;
    end else begin
      rd_en <= issuing;
      if (issuing) begin
        cnt <= cnt + 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          cnt   <= '0;
          found <= 1'b0;
          if (cmd_valid) begin
            unique case (cmd.op)
              bbsk_pkg::OP_INSERT: state <= S_SCAN;
              bbsk_pkg::OP_DUMP:   state <= S_LOAD;
              default:             state <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          if (rd_en && (eff_s > mx)) begin
            found <= 1'b1;
          end
          if (rd_en && rd_last) begin
            state <= S_INS;
          end
        end
        S_INS: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        S_LOAD: begin
          if (rd_en && rd_last) begin
            cnt   <= '0;
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (go) begin
            cnt <= cnt + 1'b1;
            if (cnt == bbsk_pkg::CNT_W'(bbsk_pkg::SLOTS - 1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/banked_best_score_keeper_top.sv
// ----------------------------------------------------------------------------
// banked_best_score_keeper_top
// Keeps the lowest scoring key candidates of each bank; insert, clear, dump.
// ----------------------------------------------------------------------------
// Input beats enter on push/full; results leave on empty/pop, oldest first.
// shown_count is written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// Insert: one result beat; one store read per slot for the max scan, then
//   the replace write.
// Clear: no result; all scores return to 100.0 at once.
// Dump: shown_count result beats, clamped to 1..N_MAX, after SLOTS reads
//   into the sort row, then SLOTS write backs.
// A two-entry command queue takes the next beats while the back works.
// Mode 3 and out-of-range banks are taken and dropped.
// Reset (synchronous) empties both queues, restores shown_count to 8, keys
// to zero and scores to 100.0 with no clearing pass.
// When the receiver stalls the result queue fills, the back waits and then
// full rises once the command queue is full.
// ----------------------------------------------------------------------------
module banked_best_score_keeper_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic [bbsk_pkg::MODE_W-1:0]           mode,
  input  logic [bbsk_pkg::BANK_W-1:0]           bank,
  input  logic [bbsk_pkg::KEY_W-1:0]            key_word,
  input  logic signed [bbsk_pkg::SCORE_W-1:0]   cand_score,
  input  logic                                  cfg_we,
  input  logic [bbsk_pkg::CFG_W-1:0]            cfg_wdata,
  output logic                                  empty,
  input  logic                                  pop,
  output logic [bbsk_pkg::SLOTOUT_W-1:0]        slot,
  output logic [bbsk_pkg::KEY_W-1:0]            out_key,
  output logic signed [bbsk_pkg::SCORE_W-1:0]   out_score,
  output logic                                  replaced,
  output logic                                  last
);

  bbsk_pkg::cmd_t front_cmd;
  bbsk_pkg::cmd_t back_cmd;
  bbsk_pkg::res_t back_res;
  bbsk_pkg::res_t head;
  logic           cmd_push;
  logic           cmd_valid;
  logic           cmd_pop;
  logic           res_push;
  logic           res_full;

  bbsk_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .mode       (mode),
    .bank       (bank),
    .key_word   (key_word),
    .cand_score (cand_score),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_full     (full),
    .cmd_push   (cmd_push),
    .cmd        (front_cmd)
  );

  bbsk_cmd_fifo u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (cmd_push),
    .wdata (front_cmd),
    .full  (full),
    .rd    (cmd_pop),
    .valid (cmd_valid),
    .rdata (back_cmd)
  );

  bbsk_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (back_cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (back_res)
  );

  bbsk_res_fifo u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_push),
    .wdata (back_res),
    .full  (res_full),
    .rd    (pop),
    .empty (empty),
    .rdata (head)
  );

  assign slot      = head.slot;
  assign out_key   = head.key;
  assign out_score = head.score;
  assign replaced  = head.replaced;
  assign last      = head.last;

endmodule

// File: rtl/bbsk_checker.sv
// ----------------------------------------------------------------------------
// bbsk_checker
// Port-level checks of the banked best score keeper, bound to the top level.
// ----------------------------------------------------------------------------
module bbsk_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                full,
  input logic                                empty,
  input logic                                pop,
  input logic [bbsk_pkg::SLOTOUT_W-1:0]      slot,
  input logic [bbsk_pkg::KEY_W-1:0]          out_key,
  input logic signed [bbsk_pkg::SCORE_W-1:0] out_score,
  input logic                                replaced,
  input logic                                last
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_reset_not_full: assert property (@(posedge clk) rst |=> !full)
    else $error("input full after reset");

  a_replace_is_last: assert property (@(posedge clk) disable iff (rst)
    !empty && replaced |-> last)
    else $error("replaced beat not marked last");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_key) && $stable(out_score) &&
    $stable(slot) && $stable(last))
    else $error("stalled result beat changed");

endmodule

bind banked_best_score_keeper_top bbsk_checker u_bbsk_checker (
  .clk       (clk),
  .rst       (rst),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .slot      (slot),
  .out_key   (out_key),
  .out_score (out_score),
  .replaced  (replaced),
  .last      (last)
);
